### hdl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants of the 3-D seven-point stencil
// Holds field widths, command and register codes, tap order and the
// per-item control flags that travel from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package dst_pkg;

	// Field widths.
	localparam int WORD_W      = 32;
	localparam int ROW_COUNT_W = 7;
	localparam int CFG_INDEX_W = 3;
	localparam int PLANE_W     = 16;
	localparam int NUM_TAPS    = 7;
	localparam int PROD_W      = 2 * WORD_W;
	localparam int FRAC_BITS   = 30;

	// Input command codes.
	localparam logic CMD_CELL  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_CENTER = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_EAST   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_WEST   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_NORTH  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_SOUTH  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_TOP    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_BOTTOM = 3'd7;

	localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 7'd64;

	// Tap order of the stencil.
	localparam int TAP_CENTER = 0;
	localparam int TAP_EAST   = 1;
	localparam int TAP_WEST   = 2;
	localparam int TAP_NORTH  = 3;
	localparam int TAP_SOUTH  = 4;
	localparam int TAP_TOP    = 5;
	localparam int TAP_BOTTOM = 6;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [NUM_TAPS-1:0] tap_vec_t;

	// Per-item control decided at acceptance.
	typedef struct packed {
		logic res;      // item produces a result
		logic last;     // result closes the grid
		logic e_ok;     // east neighbor inside the grid
		logic w_ok;     // west neighbor inside the grid
		logic n_ok;     // north neighbor inside the grid
		logic s_ok;     // south neighbor inside the rows in use
		logic top_ctr;  // top neighbor replaced by the center (drain)
		logic first;    // first plane: bottom replaced by the center
	} flags_t;

endpackage

### hdl/dst_ram.sv
// ----------------------------------------------------------------------------
// dst_ram: plane store copy with one write port and two read ports
// Read data is registered and returns the old contents on a same-address
// write in the same cycle.
// ----------------------------------------------------------------------------
module dst_ram #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	// Write and read in one clocked block: reads see the previous contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### hdl/dst_seq.sv
// ----------------------------------------------------------------------------
// dst_seq: position sequencer of the stencil
// Tracks the raster position, plane count and drain state, decides whether
// an item is taken, and forms the plane store addresses for that item.
// ----------------------------------------------------------------------------
module dst_seq #(
	parameter int GRID_X   = 64,
	parameter int MAX_ROWS = 64,
	localparam int PLANE_CELLS = GRID_X * MAX_ROWS,
	localparam int AW          = $clog2(2 * PLANE_CELLS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            cmd,
	input  logic [dst_pkg::ROW_COUNT_W-1:0] row_count,
	output logic                            take,
	output dst_pkg::flags_t                 flags,
	output logic                            we,
	output logic [AW-1:0]                   addr_cur,
	output logic [AW-1:0]                   addr_a,
	output logic [AW-1:0]                   addr_n,
	output logic [AW-1:0]                   addr_s
);

	localparam int XW  = $clog2(GRID_X);
	localparam int YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CW  = ((RW > dst_pkg::ROW_COUNT_W) ? RW : dst_pkg::ROW_COUNT_W) + 1;

	logic [XW-1:0]              x_q;
	logic [YW-1:0]              y_q;
	logic [dst_pkg::PLANE_W-1:0] z_q;
	logic                       drain_q;

	logic [CW-1:0] rc_ext;
	logic [CW-1:0] rows;
	logic [CW-1:0] y_ext;
	logic [CW-1:0] y_inc;
	logic [XW-1:0] x_next;
	logic [YW-1:0] y_next;
	logic [YW-1:0] y_prev;
	logic          x_last;
	logic          ny_ok;
	logic          d_last;
	logic          is_cell;
	logic          z_zero;
	logic          mid;
	logic          cur;

	// Linear store address of cell (x, y) in one of the two plane slots.
	function automatic logic [AW-1:0] cell_addr(input logic slot,
			input logic [YW-1:0] y, input logic [XW-1:0] x);
		cell_addr = (slot ? AW'(PLANE_CELLS) : AW'(0)) + AW'(y) * AW'(GRID_X) + AW'(x);
	endfunction

	// Rows in use: zero counts as one, large values clamp to the maximum.
	assign rc_ext = CW'(row_count);
	always_comb begin
		if (row_count == '0) begin
			rows = CW'(1);
		end else if (rc_ext > CW'(MAX_ROWS)) begin
			rows = CW'(MAX_ROWS);
		end else begin
			rows = rc_ext;
		end
	end

	// Position arithmetic.
	assign y_ext   = CW'(y_q);
	assign y_inc   = y_ext + CW'(1);
	assign x_next  = x_q + XW'(1);
	assign y_next  = YW'(y_inc);
	assign y_prev  = y_q - YW'(1);
	assign x_last  = (x_q == XW'(GRID_X - 1));
	assign ny_ok   = (y_inc < rows);
	assign d_last  = (y_ext >= rows) || ((y_inc == rows) && x_last);
	assign is_cell = (cmd == dst_pkg::CMD_CELL);
	assign z_zero  = (z_q == '0);
	assign mid     = ~z_q[0];
	assign cur     = z_q[0];

	// Acceptance decision and per-item flags.
	always_comb begin
		if (is_cell) begin
			take = ~drain_q;
		end else begin
			take = ~z_zero && (drain_q || ((x_q == '0) && (y_q == '0)));
		end
		flags.res     = is_cell ? ~z_zero : 1'b1;
		flags.last    = ~is_cell && d_last;
		flags.e_ok    = ~x_last;
		flags.w_ok    = (x_q != '0);
		flags.n_ok    = (y_q != '0);
		flags.s_ok    = ny_ok;
		flags.top_ctr = ~is_cell;
		flags.first   = (z_q == dst_pkg::PLANE_W'(1));
	end

	// Store addresses. Port A reads the east cell, or at the end of a row
	// the center of the next position, so the center always comes ready.
	always_comb begin
		addr_cur = cell_addr(cur, y_q, x_q);
		if (~x_last) begin
			addr_a = cell_addr(mid, y_q, x_next);
		end else if (ny_ok) begin
			addr_a = cell_addr(mid, y_next, XW'(0));
		end else begin
			addr_a = cell_addr(cur, YW'(0), XW'(0));
		end
		addr_n = cell_addr(mid, (y_q != '0) ? y_prev : y_q, x_q);
		addr_s = cell_addr(mid, ny_ok ? y_next : y_q, x_q);
	end

	assign we = accept && take && is_cell;

	// Position, plane and drain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			drain_q <= 1'b0;
		end else if (accept && take) begin
			if (is_cell) begin
				if (x_last) begin
					x_q <= '0;
					if (ny_ok) begin
						y_q <= y_next;
					end else begin
						y_q <= '0;
						z_q <= z_q + dst_pkg::PLANE_W'(1);
					end
				end else begin
					x_q <= x_next;
				end
			end else if (d_last) begin
				x_q     <= '0;
				y_q     <= '0;
				z_q     <= '0;
				drain_q <= 1'b0;
			end else begin
				drain_q <= 1'b1;
				if (x_last) begin
					x_q <= '0;
					y_q <= y_next;
				end else begin
					x_q <= x_next;
				end
			end
		end
	end

endmodule

### hdl/dst_mac.sv
// ----------------------------------------------------------------------------
// dst_mac: multiply, accumulate, round and saturate pipeline
// Seven Q1.30 products, an adder tree of pairs, quads and a final sum, then
// round to nearest (ties up) and saturate to 32 bits into the output register.
// ----------------------------------------------------------------------------
module dst_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_last,
	input  dst_pkg::tap_vec_t          taps,
	input  dst_pkg::tap_vec_t          coefs,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dst_pkg::WORD_W-1:0] out_value,
	output logic                       out_last
);

	localparam int PAIR_W  = dst_pkg::PROD_W + 1;
	localparam int QUAD_W  = dst_pkg::PROD_W + 2;
	localparam int SCALE_W = QUAD_W - dst_pkg::FRAC_BITS;
	localparam logic signed [PAIR_W-1:0] ROUND_HALF = PAIR_W'(1) <<< (dst_pkg::FRAC_BITS - 1);

	logic v2_s2, v3_s3, v4_s4, v5_s5;
	logic en2, en3, en4, en5;
	logic last_s2, last_s3, last_s4;

	logic signed [dst_pkg::PROD_W-1:0] prod_s2 [dst_pkg::NUM_TAPS];
	logic signed [PAIR_W-1:0]          pair_s3 [4];
	logic signed [QUAD_W-1:0]          quad_s4 [2];

	logic signed [QUAD_W-1:0]  total;
	logic signed [SCALE_W-1:0] scaled;
	logic [dst_pkg::WORD_W-1:0] sat;

	// Stage enables: a stage loads when it is empty or moves on.
	assign en5      = ~v5_s5 || out_ready;
	assign en4      = ~v4_s4 || en5;
	assign en3      = ~v3_s3 || en4;
	assign en2      = ~v2_s2 || en3;
	assign in_ready = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (en2) v2_s2 <= in_valid;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
		end
	end

	// Products, pairwise sums with the rounding half folded in, and quads.
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < dst_pkg::NUM_TAPS; i++) begin
				prod_s2[i] <= $signed(taps[i]) * $signed(coefs[i]);
			end
			last_s2 <= in_last;
		end
		if (en3) begin
			pair_s3[0] <= PAIR_W'(prod_s2[0]) + PAIR_W'(prod_s2[1]);
			pair_s3[1] <= PAIR_W'(prod_s2[2]) + PAIR_W'(prod_s2[3]);
			pair_s3[2] <= PAIR_W'(prod_s2[4]) + PAIR_W'(prod_s2[5]);
			pair_s3[3] <= PAIR_W'(prod_s2[6]) + ROUND_HALF;
			last_s3    <= last_s2;
		end
		if (en4) begin
			quad_s4[0] <= QUAD_W'(pair_s3[0]) + QUAD_W'(pair_s3[1]);
			quad_s4[1] <= QUAD_W'(pair_s3[2]) + QUAD_W'(pair_s3[3]);
			last_s4    <= last_s3;
		end
		if (en5) begin
			out_value <= sat;
			out_last  <= last_s4;
		end
	end

	// Final sum, drop the fraction and clamp to the 32-bit range.
	assign total  = quad_s4[0] + quad_s4[1];
	assign scaled = total[QUAD_W-1:dst_pkg::FRAC_BITS];

	always_comb begin
		if (~scaled[SCALE_W-1] && (|scaled[SCALE_W-2:dst_pkg::WORD_W-1])) begin
			sat = {1'b0, {(dst_pkg::WORD_W-1){1'b1}}};
		end else if (scaled[SCALE_W-1] && ~(&scaled[SCALE_W-2:dst_pkg::WORD_W-1])) begin
			sat = {1'b1, {(dst_pkg::WORD_W-1){1'b0}}};
		end else begin
			sat = scaled[dst_pkg::WORD_W-1:0];
		end
	end

	assign out_valid = v5_s5;

endmodule

### hdl/diffusion_stencil_3d.sv
// ----------------------------------------------------------------------------
// diffusion_stencil_3d: one streaming sweep of a 3-D seven-point stencil
// Stages: first stage, then MAC product, pair, quad and output registers.
// Throughput: one item per cycle unless out_ready stalls, set by one
// store access per port per item (two store copies, two read ports each) and a
// fully pipelined datapath. Reset: row_count 64, coefficients zero, positions
// cleared; the plane store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module diffusion_stencil_3d #(
	parameter int GRID_X   = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic signed [dst_pkg::WORD_W-1:0] cell_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [dst_pkg::WORD_W-1:0] new_value,
	output logic                            grid_last,
	input  logic                            cfg_write,
	input  logic [dst_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dst_pkg::WORD_W-1:0]      cfg_data
);

	localparam int PLANE_CELLS = GRID_X * MAX_ROWS;
	localparam int DEPTH       = 2 * PLANE_CELLS;
	localparam int AW          = $clog2(DEPTH);

	logic [dst_pkg::ROW_COUNT_W-1:0] row_count_q;
	dst_pkg::tap_vec_t               coef_q;

	logic            accept;
	logic            take;
	dst_pkg::flags_t flags;
	logic            we;
	logic [AW-1:0]   addr_cur, addr_a, addr_n, addr_s;

	logic [dst_pkg::WORD_W-1:0] rd_east, rd_north, rd_south, rd_bottom;

	logic                   v1_s1;
	dst_pkg::flags_t        flags_s1;
	dst_pkg::word_t         sample_s1;
	logic                   s1_go;
	logic                   mac_ready;
	dst_pkg::word_t         fwd_q;
	dst_pkg::word_t         prev_ctr_q;
	dst_pkg::tap_vec_t      taps;
	logic [dst_pkg::WORD_W-1:0] mac_value;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= dst_pkg::ROW_COUNT_RESET;
			coef_q      <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				dst_pkg::REG_ROW_COUNT:   row_count_q <= cfg_data[dst_pkg::ROW_COUNT_W-1:0];
				dst_pkg::REG_COEF_CENTER: coef_q[dst_pkg::TAP_CENTER] <= cfg_data;
				dst_pkg::REG_COEF_EAST:   coef_q[dst_pkg::TAP_EAST]   <= cfg_data;
				dst_pkg::REG_COEF_WEST:   coef_q[dst_pkg::TAP_WEST]   <= cfg_data;
				dst_pkg::REG_COEF_NORTH:  coef_q[dst_pkg::TAP_NORTH]  <= cfg_data;
				dst_pkg::REG_COEF_SOUTH:  coef_q[dst_pkg::TAP_SOUTH]  <= cfg_data;
				dst_pkg::REG_COEF_TOP:    coef_q[dst_pkg::TAP_TOP]    <= cfg_data;
				dst_pkg::REG_COEF_BOTTOM: coef_q[dst_pkg::TAP_BOTTOM] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input handshake: the first stage loads when empty or moving on.
	assign s1_go    = v1_s1 && (~flags_s1.res || mac_ready);
	assign in_ready = ~v1_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	dst_seq #(
		.GRID_X   (GRID_X),
		.MAX_ROWS (MAX_ROWS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.row_count (row_count_q),
		.take      (take),
		.flags     (flags),
		.we        (we),
		.addr_cur  (addr_cur),
		.addr_a    (addr_a),
		.addr_n    (addr_n),
		.addr_s    (addr_s)
	);

	// Two copies of the plane store, written alike, give four read ports.
	dst_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (dst_pkg::WORD_W)
	) u_ram_0 (
		.clk     (clk),
		.we      (we),
		.waddr   (addr_cur),
		.wdata   (cell_value),
		.re      (accept),
		.raddr_a (addr_a),
		.raddr_b (addr_n),
		.rdata_a (rd_east),
		.rdata_b (rd_north)
	);

	dst_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (dst_pkg::WORD_W)
	) u_ram_1 (
		.clk     (clk),
		.we      (we),
		.waddr   (addr_cur),
		.wdata   (cell_value),
		.re      (accept),
		.raddr_a (addr_s),
		.raddr_b (addr_cur),
		.rdata_a (rd_south),
		.rdata_b (rd_bottom)
	);

	// First stage: valid bit and the item's flags and sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (in_ready) begin
			v1_s1 <= in_valid && take;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1  <= flags;
			sample_s1 <= cell_value;
		end
	end

	// Window along the row: the port A read of one item is the next item's
	// center, and each center becomes the next item's west neighbor.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			fwd_q      <= rd_east;
			prev_ctr_q <= fwd_q;
		end
	end

	// Neighbor selection; a neighbor outside the grid takes the center.
	always_comb begin
		taps[dst_pkg::TAP_CENTER] = fwd_q;
		taps[dst_pkg::TAP_EAST]   = flags_s1.e_ok ? rd_east : fwd_q;
		taps[dst_pkg::TAP_WEST]   = flags_s1.w_ok ? prev_ctr_q : fwd_q;
		taps[dst_pkg::TAP_NORTH]  = flags_s1.n_ok ? rd_north : fwd_q;
		taps[dst_pkg::TAP_SOUTH]  = flags_s1.s_ok ? rd_south : fwd_q;
		taps[dst_pkg::TAP_TOP]    = flags_s1.top_ctr ? fwd_q : sample_s1;
		taps[dst_pkg::TAP_BOTTOM] = flags_s1.first ? fwd_q : rd_bottom;
	end

	dst_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1_s1 && flags_s1.res),
		.in_ready  (mac_ready),
		.in_last   (flags_s1.last),
		.taps      (taps),
		.coefs     (coef_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_value (mac_value),
		.out_last  (grid_last)
	);

	assign new_value = $signed(mac_value);

endmodule

### tb/tb_diffusion_stencil_3d.sv
// ----------------------------------------------------------------------------
// tb_diffusion_stencil_3d: self-checking bench for the 3-D seven-point stencil
// Streams whole grids of cells followed by their drain items, with stray items
// that the block has to drop, under random gaps on both handshakes. A private
// model of the plane store and the fixed-point sum predicts every result, and
// results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_diffusion_stencil_3d;
	timeunit 1ns;
	timeprecision 1ps;

	import dst_pkg::*;

	localparam int GRID_X        = 64;
	localparam int MAX_ROWS      = 64;
	localparam int PLANE_CELLS   = GRID_X * MAX_ROWS;
	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_ITEMS  = 800;
	localparam int N_EXTREME     = 8;

	localparam word_t EXTREME_WORDS [N_EXTREME] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h2000_0000, 32'hE000_0000, 32'h3FFF_FFFF
	};

	localparam logic signed [PROD_W+7:0] HALF_LSB = 72'sd536870912;
	localparam logic signed [PROD_W+7:0] SAT_MAX  = 72'sd2147483647;
	localparam logic signed [PROD_W+7:0] SAT_MIN  = -72'sd2147483648;

	typedef enum {SAMPLE_MIXED, SAMPLE_TIES, SAMPLE_EXTREME} sample_mode_e;

	typedef struct {
		logic  cmd;
		word_t value;
	} sweep_item_t;

	typedef struct {
		word_t value;
		logic  last;
	} stencil_result_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_ready;
	logic                     cmd        = CMD_CELL;
	logic signed [WORD_W-1:0] cell_value = '0;
	logic                     out_valid;
	logic                     out_ready  = 1'b0;
	logic signed [WORD_W-1:0] new_value;
	logic                     grid_last;
	logic                     cfg_write  = 1'b0;
	logic [CFG_INDEX_W-1:0]   cfg_index  = REG_ROW_COUNT;
	logic [WORD_W-1:0]        cfg_data   = '0;

	// Predictor state: plane store, positions and a copy of the registers.
	word_t                  sweep_store [2*PLANE_CELLS];
	int unsigned            col_at   = 0;
	int unsigned            row_at   = 0;
	int unsigned            plane_at = 0;
	int unsigned            drain_at = 0;
	logic [ROW_COUNT_W-1:0] row_count_cfg = ROW_COUNT_RESET;
	word_t                  coef_cfg [NUM_TAPS] = '{default: '0};

	sweep_item_t     cell_stream[$];
	stencil_result_t expected_cells[$];
	int unsigned     queued_items = 0;
	int unsigned     taken_items  = 0;
	int unsigned     sweep_items  = 0;
	int unsigned     error_count  = 0;
	int unsigned     idle_cycles  = 0;
	int unsigned     src_gap      = 0;
	int unsigned     sink_stall   = 0;
	bit              src_calm     = 1'b0;
	bit              sink_calm    = 1'b0;

	diffusion_stencil_3d #(
		.GRID_X  (GRID_X),
		.MAX_ROWS(MAX_ROWS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.cell_value(cell_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.new_value (new_value),
		.grid_last (grid_last),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Rows in use after clamping the register to 1..MAX_ROWS.
	function automatic int unsigned rows_active();
		if (row_count_cfg == 0) return 1;
		if (row_count_cfg > MAX_ROWS) return MAX_ROWS;
		return row_count_cfg;
	endfunction

	function automatic word_t stored(int unsigned slot, int unsigned y, int unsigned x);
		return sweep_store[(slot % 2) * PLANE_CELLS + y * GRID_X + x];
	endfunction

	// Weighted sum of the seven taps at full width, rounded half up, saturated.
	function automatic word_t stencil_value(int unsigned x, int unsigned y, int unsigned mid,
			word_t top, bit first_plane);
		word_t                     tap [NUM_TAPS];
		logic signed [PROD_W+7:0]  acc;
		logic signed [PROD_W+7:0]  rounded;
		longint                    prod;
		tap[TAP_CENTER] = stored(mid, y, x);
		tap[TAP_EAST]   = (x + 1 >= GRID_X) ? tap[TAP_CENTER] : stored(mid, y, x + 1);
		tap[TAP_WEST]   = (x == 0) ? tap[TAP_CENTER] : stored(mid, y, x - 1);
		tap[TAP_NORTH]  = (y == 0) ? tap[TAP_CENTER] : stored(mid, y - 1, x);
		tap[TAP_SOUTH]  = (y + 1 >= rows_active()) ? tap[TAP_CENTER] : stored(mid, y + 1, x);
		tap[TAP_TOP]    = top;
		tap[TAP_BOTTOM] = first_plane ? tap[TAP_CENTER] : stored(mid + 1, y, x);
		acc = '0;
		for (int i = 0; i < NUM_TAPS; i++) begin
			prod = longint'(signed'(tap[i])) * longint'(signed'(coef_cfg[i]));
			acc += prod;
		end
		rounded = (acc + HALF_LSB) >>> FRAC_BITS;
		if (rounded > SAT_MAX) return 32'h7FFF_FFFF;
		if (rounded < SAT_MIN) return 32'h8000_0000;
		return rounded[WORD_W-1:0];
	endfunction

	// Advances the predictor by one accepted item and queues its result, if any.
	task automatic predict_sweep(logic item_cmd, word_t sample);
		int unsigned     rows;
		int unsigned     x;
		int unsigned     y;
		int unsigned     z;
		int unsigned     d;
		stencil_result_t res;
		rows = rows_active();
		z = plane_at;
		if (item_cmd == CMD_CELL) begin
			// Cells are dropped while a drain is under way.
			if (drain_at != 0) return;
			x = col_at;
			y = row_at;
			// The new cell is the top neighbor of the same cell one plane back.
			if (z != 0) begin
				res.value = stencil_value(x, y, (z - 1) % 2, sample, z == 1);
				res.last  = 1'b0;
				expected_cells.push_back(res);
			end
			sweep_store[(z % 2) * PLANE_CELLS + y * GRID_X + x] = sample;
			if (x + 1 >= GRID_X) begin
				col_at = 0;
				if (y + 1 >= rows) begin
					row_at   = 0;
					plane_at = (z + 1) % (1 << PLANE_W);
				end else begin
					row_at = y + 1;
				end
			end else begin
				col_at = x + 1;
			end
		end else begin
			// Drains count only once at least one whole plane is in.
			if (z == 0 || col_at != 0 || row_at != 0) return;
			d = drain_at;
			x = d % GRID_X;
			y = d / GRID_X;
			if (y >= MAX_ROWS) y = MAX_ROWS - 1;
			res.value = stencil_value(x, y, (z - 1) % 2, stored((z - 1) % 2, y, x), z == 1);
			res.last  = (d + 1 >= GRID_X * rows);
			expected_cells.push_back(res);
			if (res.last) begin
				drain_at = 0;
				plane_at = 0;
			end else begin
				drain_at = d + 1;
			end
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned gap_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t pick_sample(sample_mode_e mode);
		if (mode == SAMPLE_EXTREME) return EXTREME_WORDS[$urandom_range(0, N_EXTREME - 1)];
		// Multiples of half an LSB land exactly on rounding ties.
		if (mode == SAMPLE_TIES || $urandom_range(0, 15) == 0)
			return word_t'($urandom_range(0, 15)) << (FRAC_BITS - 1);
		if ($urandom_range(0, 7) == 0) return EXTREME_WORDS[$urandom_range(0, N_EXTREME - 1)];
		return $urandom;
	endfunction

	// Small diffusion-like weights most of the time, else full range or extremes.
	function automatic word_t random_coef();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 5) return word_t'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
		if (pick < 8) return $urandom;
		return EXTREME_WORDS[$urandom_range(0, N_EXTREME - 1)];
	endfunction

	task automatic push_item(logic item_cmd, word_t value);
		sweep_item_t it;
		it.cmd   = item_cmd;
		it.value = value;
		cell_stream.push_back(it);
		queued_items++;
	endtask

	// Waits until every item is taken and every result is back, then lets the
	// pipeline run empty for items that gave no result.
	task automatic settle();
		do @(posedge clk);
		while (taken_items != queued_items || expected_cells.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, word_t data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (index)
			REG_ROW_COUNT:   row_count_cfg = data[ROW_COUNT_W-1:0];
			REG_COEF_CENTER: coef_cfg[TAP_CENTER] = data;
			REG_COEF_EAST:   coef_cfg[TAP_EAST] = data;
			REG_COEF_WEST:   coef_cfg[TAP_WEST] = data;
			REG_COEF_NORTH:  coef_cfg[TAP_NORTH] = data;
			REG_COEF_SOUTH:  coef_cfg[TAP_SOUTH] = data;
			REG_COEF_TOP:    coef_cfg[TAP_TOP] = data;
			default:         coef_cfg[TAP_BOTTOM] = data;
		endcase
	endtask

	// Waits for the block to go idle, then writes every register.
	task automatic load_setting(logic [ROW_COUNT_W-1:0] rows, word_t coefs [NUM_TAPS]);
		settle();
		write_reg(REG_ROW_COUNT, word_t'(rows));
		write_reg(REG_COEF_CENTER, coefs[TAP_CENTER]);
		write_reg(REG_COEF_EAST, coefs[TAP_EAST]);
		write_reg(REG_COEF_WEST, coefs[TAP_WEST]);
		write_reg(REG_COEF_NORTH, coefs[TAP_NORTH]);
		write_reg(REG_COEF_SOUTH, coefs[TAP_SOUTH]);
		write_reg(REG_COEF_TOP, coefs[TAP_TOP]);
		write_reg(REG_COEF_BOTTOM, coefs[TAP_BOTTOM]);
	endtask

	// One well-formed grid: all planes in raster order, then one drain item per
	// cell of a plane. Stray items that the block must drop are mixed in.
	task automatic queue_grid(logic [ROW_COUNT_W-1:0] rows, int unsigned planes,
			sample_mode_e mode);
		int unsigned plane_cells;
		plane_cells = GRID_X * (rows == 0 ? 1 : (rows > MAX_ROWS ? MAX_ROWS : rows));
		for (int unsigned p = 0; p < planes; p++) begin
			for (int unsigned c = 0; c < plane_cells; c++) begin
				// A drain before the first plane is complete, or inside a plane.
				if ((p == 0 || c != 0) && $urandom_range(0, 47) == 0)
					push_item(CMD_DRAIN, $urandom);
				push_item(CMD_CELL, pick_sample(mode));
			end
		end
		for (int unsigned d = 0; d < plane_cells; d++) begin
			// A cell sent while the drain is under way.
			if (d != 0 && $urandom_range(0, 47) == 0)
				push_item(CMD_CELL, pick_sample(mode));
			push_item(CMD_DRAIN, $urandom);
		end
		// A drain after the grid has ended.
		if ($urandom_range(0, 3) == 0) push_item(CMD_DRAIN, $urandom);
		sweep_items += plane_cells * (planes + 1);
	endtask

	// Item driver: presents queued items, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		sweep_item_t queued;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			cmd        <= CMD_CELL;
			cell_value <= '0;
			src_gap    <= 0;
			src_calm   <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (src_gap != 0) begin
				src_gap  <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (cell_stream.size() != 0) begin
				queued = cell_stream.pop_front();
				in_valid   <= 1'b1;
				cmd        <= queued.cmd;
				cell_value <= queued.value;
				if ($urandom_range(0, 63) == 0) src_calm <= !src_calm;
				src_gap <= src_calm ? 0 : gap_length();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: ready drops for random stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			sink_stall <= 0;
			sink_calm  <= 1'b0;
		end else if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ((out_valid && out_ready) || $urandom_range(0, 15) == 0) begin
				if ($urandom_range(0, 63) == 0) sink_calm <= !sink_calm;
				sink_stall <= sink_calm ? 0 : gap_length();
			end
		end
	end

	// Monitor: predicts on every accepted item and checks every accepted result.
	always @(posedge clk) begin
		stencil_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_sweep(cmd, cell_value);
				taken_items++;
			end
			if (out_valid && out_ready) begin
				if (expected_cells.size() == 0) begin
					error_count++;
					$error("unexpected result: new_value %h, grid_last %b",
						new_value, grid_last);
				end else begin
					want = expected_cells.pop_front();
					if (new_value !== want.value) begin
						error_count++;
						$error("new_value: expected %h, actual %h", want.value, new_value);
					end
					if (grid_last !== want.last) begin
						error_count++;
						$error("grid_last: expected %b, actual %b", want.last, grid_last);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		word_t                  coefs [NUM_TAPS];
		logic [ROW_COUNT_W-1:0] rows;
		int unsigned            pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed grid: row count 0 means one row; extreme samples and weights,
		// drains before and inside the first plane, a cell inside the drain.
		coefs = '{32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'hFFFF_FFFF, 32'h2000_0000, 32'hE000_0000};  // center .. bottom
		load_setting(7'd0, coefs);
		push_item(CMD_DRAIN, '0);
		for (int i = 0; i < N_EXTREME; i++) begin
			push_item(CMD_CELL, EXTREME_WORDS[i]);
			if (i == 1) push_item(CMD_DRAIN, '1);
		end
		repeat (GRID_X - N_EXTREME) push_item(CMD_CELL, pick_sample(SAMPLE_MIXED));
		for (int i = N_EXTREME - 1; i >= 0; i--) push_item(CMD_CELL, EXTREME_WORDS[i]);
		repeat (GRID_X - N_EXTREME) push_item(CMD_CELL, pick_sample(SAMPLE_MIXED));
		push_item(CMD_DRAIN, '0);
		push_item(CMD_CELL, 32'h7FFF_FFFF);
		repeat (GRID_X - 1) push_item(CMD_DRAIN, $urandom);
		push_item(CMD_DRAIN, '1);

		// Saturation in both directions: full-scale weights on extreme samples.
		coefs = '{default: 32'h7FFF_FFFF};
		load_setting(7'd2, coefs);
		queue_grid(7'd2, 2, SAMPLE_EXTREME);

		// Rounding ties on a single-plane grid.
		coefs = '{default: '0};
		coefs[TAP_CENTER] = 32'h0000_0001;
		coefs[TAP_WEST]   = 32'hFFFF_FFFF;
		load_setting(7'd1, coefs);
		queue_grid(7'd1, 1, SAMPLE_TIES);

		// Random grids, mostly one row per plane.
		sweep_items = 0;
		while (sweep_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			rows = (pick == 0) ? 7'd0 : (pick < 7 ? 7'd1 : 7'($urandom_range(2, 4)));
			foreach (coefs[i]) coefs[i] = random_coef();
			load_setting(rows, coefs);
			queue_grid(rows, $urandom_range(1, 4), SAMPLE_MIXED);
		end

		settle();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
